### rtl/unsorted_list_table_defines.svh
// Assertion helpers used by unsorted_list_table; they expect clk and arst_n in scope.
`ifndef UNSORTED_LIST_TABLE_DEFINES_SVH
`define UNSORTED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ULT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ULT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ult_pkg.sv
package ult_pkg;

	// Operation codes on the request channel; codes 6 and 7 are unused.
	typedef enum logic [2:0] {
		FUNC_INSERT = 3'd0,
		FUNC_LOOKUP = 3'd1,
		FUNC_DELETE = 3'd2,
		FUNC_CLEAR  = 3'd3,
		FUNC_REWIND = 3'd4,
		FUNC_READ   = 3'd5
	} func_t;

	// What a token looks for while it walks the chain.
	typedef enum logic [1:0] {
		MODE_LOOKUP,
		MODE_DELETE,
		MODE_READ
	} tok_mode_t;

	typedef struct packed {
		logic      active;
		tok_mode_t mode;
		logic      found;
	} tok_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	localparam int PortValueBits = 32;

endpackage

### rtl/ult_if.sv
interface ult_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] value;

	modport source(output valid, output func, output value, input ready);
	modport sink(input valid, input func, input value, output ready);
endinterface

interface ult_rsp_if #(
	parameter int COUNT_BITS = 5
);
	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [31:0]           data;
	logic [COUNT_BITS-1:0] count;
	logic                  full_res;

	modport source(output valid, output ok, output data, output count, output full_res,
		input ready);
	modport sink(input valid, input ok, input data, input count, input full_res,
		output ready);
endinterface

### rtl/unsorted_list_table.sv
// Fixed-capacity unsorted list with append, lookup, delete, clear, rewind and read-next.
//
// Channels: req carries func and value, rsp returns ok, data, count and full_res.
// Both use valid/ready; a transfer happens on a rising edge with both high.
// One response comes back for every request, in order.
//
// Flow: insert, clear, rewind and the unused codes load their answer into the
// response register on the request transfer. Lookup, delete and read-next send
// a token down a chain of CAPACITY cells, one cell per cycle, and their answer
// is loaded when the token leaves the last cell. Requests are handled one at a
// time; no new request is taken while a chain walk runs.
//
// Reset: arst_n clears the count, the read cursor, the state and the
// response valid. Stored entries are not cleared; only slots below the count
// are ever read.
//
// Stall: a finished response sits in the output register until rsp.ready;
// req.ready stays low while a chain walk runs or the response cannot drain.
module unsorted_list_table #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	ult_req_if.sink    req,
	ult_rsp_if.source  rsp
);
	import ult_pkg::*;

	`include "unsorted_list_table_defines.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW = (VALUE_BITS < PortValueBits) ? VALUE_BITS : PortValueBits;

	state_t                   state_q;
	state_t                   state_d;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rpos_q;
	logic                     rsp_valid_q;
	logic                     ok_q;
	logic [PortValueBits-1:0] data_q;

	// token chain: index 0 is the launch point, index CAPACITY the exit
	tok_ctl_t      ctl_w  [CAPACITY+1];
	logic [EW-1:0] key_w  [CAPACITY+1];
	logic [IW-1:0] idx_w  [CAPACITY+1];
	logic [EW-1:0] data_w [CAPACITY+1];

	func_t                    func;
	logic                     accept;
	logic                     out_free;
	logic                     exit_tok;
	logic                     has_room;
	tok_ctl_t                 launch_ctl;
	logic                     wr_en;
	logic [IW-1:0]            wr_idx;
	logic [EW-1:0]            wr_data;
	logic                     res_load;
	logic                     res_ok;
	logic [PortValueBits-1:0] res_data;
	logic                     dec_count;
	logic                     adv_rpos;

	assign func     = func_t'(req.func);
	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign exit_tok = ctl_w[CAPACITY].active;
	assign has_room = count_q < CW'(CAPACITY);

	// Launch point of the chain.
	assign ctl_w[0]  = launch_ctl;
	assign key_w[0]  = req.value[EW-1:0];
	assign idx_w[0]  = '0;
	assign data_w[0] = '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (func == FUNC_LOOKUP || func == FUNC_DELETE ||
					func == FUNC_READ)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (exit_tok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the controller: handshake, token launch, slot write, result.
	always_comb begin
		req.ready         = (state_q == ST_IDLE) && out_free;
		launch_ctl.active = 1'b0;
		launch_ctl.mode   = MODE_LOOKUP;
		launch_ctl.found  = 1'b0;
		wr_en             = 1'b0;
		wr_idx            = IW'(count_q);
		wr_data           = req.value[EW-1:0];
		res_load          = 1'b0;
		res_ok            = 1'b0;
		res_data          = '0;
		dec_count         = 1'b0;
		adv_rpos          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_INSERT: begin
							// append at the tail when there is room
							wr_en    = has_room;
							res_load = 1'b1;
							res_ok   = has_room;
						end
						FUNC_LOOKUP: begin
							launch_ctl.active = 1'b1;
							launch_ctl.mode   = MODE_LOOKUP;
						end
						FUNC_DELETE: begin
							launch_ctl.active = 1'b1;
							launch_ctl.mode   = MODE_DELETE;
						end
						FUNC_READ: begin
							launch_ctl.active = 1'b1;
							launch_ctl.mode   = MODE_READ;
						end
						default: begin
							// clear, rewind and unused codes answer at once
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (exit_tok) begin
					res_load = 1'b1;
					res_ok   = ctl_w[CAPACITY].found;
					if (ctl_w[CAPACITY].found) begin
						case (ctl_w[CAPACITY].mode)
							MODE_DELETE: begin
								// move the tail entry into the hole
								wr_en     = 1'b1;
								wr_idx    = idx_w[CAPACITY];
								wr_data   = data_w[CAPACITY];
								dec_count = 1'b1;
							end
							MODE_READ: begin
								res_data = PortValueBits'(data_w[CAPACITY]);
								adv_rpos = 1'b1;
							end
							default: begin
								res_data = PortValueBits'(data_w[CAPACITY]);
							end
						endcase
					end
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ult_cell #(
			.CW  (CW),
			.IW  (IW),
			.EW  (EW),
			.IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_idx  (wr_idx),
			.wr_data (wr_data),
			.count   (count_q),
			.rpos    (rpos_q),
			.up_ctl  (ctl_w[g]),
			.up_key  (key_w[g]),
			.up_idx  (idx_w[g]),
			.up_data (data_w[g]),
			.dn_ctl  (ctl_w[g+1]),
			.dn_key  (key_w[g+1]),
			.dn_idx  (idx_w[g+1]),
			.dn_data (data_w[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rpos_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a new response, else drop the old one once transferred
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept && func == FUNC_INSERT && has_room) begin
				count_q <= count_q + CW'(1);
			end
			if (accept && func == FUNC_CLEAR) begin
				count_q <= '0;
			end
			if (accept && func == FUNC_REWIND) begin
				rpos_q <= '0;
			end
			if (dec_count) begin
				count_q <= count_q - CW'(1);
			end
			if (adv_rpos) begin
				rpos_q <= rpos_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			ok_q   <= res_ok;
			data_q <= res_data;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.data     = data_q;
	assign rsp.count    = count_q;
	assign rsp.full_res = count_q == CW'(CAPACITY);

	`ULT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`ULT_ASSERT_IMPL(a_walk_len, exit_tok, $past(ctl_w[0].active, CAPACITY), "stray exit")
	`ULT_ASSERT_IMPL(a_busy_empty, state_q != ST_IDLE, !rsp_valid_q, "response pending during walk")
	`ULT_ASSERT_NEXT(a_delete_dec, dec_count, count_q == $past(count_q) - CW'(1), "delete count slip")

endmodule

### rtl/ult_cell.sv
module ult_cell #(
	parameter int CW  = 5,
	parameter int IW  = 4,
	parameter int EW  = 32,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_idx,
	input  logic [EW-1:0]    wr_data,
	input  logic [CW-1:0]    count,
	input  logic [CW-1:0]    rpos,
	input  ult_pkg::tok_ctl_t up_ctl,
	input  logic [EW-1:0]    up_key,
	input  logic [IW-1:0]    up_idx,
	input  logic [EW-1:0]    up_data,
	output ult_pkg::tok_ctl_t dn_ctl,
	output logic [EW-1:0]    dn_key,
	output logic [IW-1:0]    dn_idx,
	output logic [EW-1:0]    dn_data
);
	import ult_pkg::*;

	logic [EW-1:0] entry_q;
	tok_ctl_t      ctl_q;
	logic [EW-1:0] key_q;
	logic [IW-1:0] idx_q;
	logic [EW-1:0] data_q;

	tok_ctl_t      ctl_d;
	logic [IW-1:0] idx_d;
	logic [EW-1:0] data_d;
	logic          in_list;
	logic          is_last;

	assign in_list = CW'(IDX) < count;
	assign is_last = CW'(IDX + 1) == count;

	// Update the passing token with what this slot holds.
	always_comb begin
		ctl_d  = up_ctl;
		idx_d  = up_idx;
		data_d = up_data;
		if (up_ctl.active) begin
			case (up_ctl.mode)
				MODE_LOOKUP: begin
					if (in_list && !up_ctl.found && entry_q == up_key) begin
						ctl_d.found = 1'b1;
						idx_d       = IW'(IDX);
						data_d      = entry_q;
					end
				end
				MODE_DELETE: begin
					if (in_list && !up_ctl.found && entry_q == up_key) begin
						ctl_d.found = 1'b1;
						idx_d       = IW'(IDX);
					end
					// grab the tail entry that fills the hole
					if (is_last) begin
						data_d = entry_q;
					end
				end
				MODE_READ: begin
					if (in_list && CW'(IDX) == rpos) begin
						ctl_d.found = 1'b1;
						data_d      = entry_q;
					end
				end
				default: begin
					ctl_d = up_ctl;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= up_key;
		idx_q  <= idx_d;
		data_q <= data_d;
		if (wr_en && wr_idx == IW'(IDX)) begin
			entry_q <= wr_data;
		end
	end

	assign dn_ctl  = ctl_q;
	assign dn_key  = key_q;
	assign dn_idx  = idx_q;
	assign dn_data = data_q;

endmodule
